// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// BCC_ASSERT expects signals named clk and rst_n, BCC_ASSERT_ALWAYS only clk, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define BCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BCC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bcc_pkg.sv =====
package bcc_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int BIN_COUNT = 256;
    localparam int THR_W     = 16;
    localparam int LEN_W     = 6;
    localparam int STAT_W    = 18;

    // Threshold after reset
    localparam logic [THR_W-1:0] THR_RESET = 16'd512;

    // One input beat: a byte of the file stream
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_file;
    } byte_beat_t;

    // One result beat: the verdict on a finished chunk
    typedef struct packed {
        logic              chunk_random;
        logic              file_random;
        logic              file_done;
        logic [LEN_W-1:0]  chunk_length;
        logic [STAT_W-1:0] chunk_stat;
    } result_beat_t;

endpackage

// ===== src/bcc_stream_if.sv =====
// Valid/ready channel carrying one payload per beat.
interface bcc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/bcc_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written in the same cycle returns the old data.
module bcc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/byte_chunk_chi_square_tester.sv =====
// Channel      Dir  Beat contents
// byte_in      in   data_byte, end_of_file
// result_out   out  chunk_random, file_random, file_done, chunk_length, chunk_stat
// cfg_write_*  in   chunk_threshold (written when cfg_write_en is high)
//
// One byte is taken every cycle unless the pipeline holds; the bin
// read-modify-write through the count RAM (registered read, forwarding of the
// previous write) sets that rate. Results pass the closing and result registers.
// Reset clears all bins at once through per-bin valid flags; no clearing pass.
// A waiting result stalls the byte input only when a further result is ready
// to follow it.
module byte_chunk_chi_square_tester
    import bcc_pkg::*;
#(
    parameter int CHUNK_BYTES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    bcc_stream_if.sink          byte_in,
    bcc_stream_if.source        result_out,
    input  logic                cfg_write_en,
    input  logic [THR_W-1:0]    cfg_write_data
);

    localparam int CNT_W  = $clog2(CHUNK_BYTES + 1);
    localparam int SUM_W  = $clog2(CHUNK_BYTES * CHUNK_BYTES + 1);
    localparam int ADDR_W = $clog2(BIN_COUNT);
    localparam int TPN_W  = THR_W + 1;
    localparam int PROD_W = CNT_W + TPN_W;
    localparam int CMP_W  = (SUM_W + 8 > PROD_W) ? SUM_W + 8 : PROD_W;

    // Threshold register
    logic [THR_W-1:0] thr_reg;

    // Byte stage: the byte whose bin is being updated
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_byte_reg;
    logic              s1_eof_reg;

    // Last bin write, for the read that was issued at the same edge
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]  fwd_cnt_reg;

    // Chunk state
    logic [BIN_COUNT-1:0] bin_valid_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     n_reg;
    logic                 all_random_reg;

    // Closing stage: a finished chunk waiting for its verdict
    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [CNT_W-1:0] s2_n_reg;
    logic             s2_eof_reg;

    // Result register
    logic         out_valid_reg;
    result_beat_t out_payload_reg;

    logic             advance;
    logic             in_accept;
    logic             s1_fire;
    logic [CNT_W-1:0] ram_rdata;
    logic [CNT_W-1:0] cnt_old;
    logic [CNT_W-1:0] cnt_new;
    logic [CNT_W-1:0] n_new;
    logic [SUM_W-1:0] sum_new;
    logic             chunk_close;

    logic [TPN_W-1:0]   thr_plus_n;
    logic [PROD_W-1:0]  rhs;
    logic [CMP_W-1:0]   lhs;
    logic [2*CNT_W-1:0] n_sq;
    logic [CMP_W-1:0]   stat;
    logic               verdict;
    logic               file_verdict;

    // The pipeline holds only when a result waits and another stands behind it
    assign advance   = !(s2_valid_reg && out_valid_reg && !result_out.ready);
    assign in_accept = byte_in.valid && advance;
    assign s1_fire   = s1_valid_reg && advance;

    assign byte_in.ready = advance;

    // Bin counts
    bcc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_byte_reg),
        .wdata (cnt_new),
        .re    (in_accept),
        .raddr (byte_in.payload.data_byte),
        .rdata (ram_rdata)
    );

    // Old count of the bin: zero if untouched in this chunk, else the RAM or
    // the write that landed at the edge where the read was issued.
    always_comb
    begin
        if (!bin_valid_reg[s1_byte_reg])
        begin
            cnt_old = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == s1_byte_reg))
        begin
            cnt_old = fwd_cnt_reg;
        end
        else
        begin
            cnt_old = ram_rdata;
        end
    end

    // Each byte adds 2c+1 to the sum of squares
    assign cnt_new     = cnt_old + CNT_W'(1);
    assign n_new       = n_reg + CNT_W'(1);
    assign sum_new     = sum_reg + SUM_W'({cnt_old, 1'b1});
    assign chunk_close = (n_new == CNT_W'(CHUNK_BYTES)) || s1_eof_reg;

    // Verdict: 256*S < n*(threshold+n), statistic 256*S - n*n
    assign thr_plus_n   = {1'b0, thr_reg} + TPN_W'(s2_n_reg);
    assign rhs          = PROD_W'(s2_n_reg) * PROD_W'(thr_plus_n);
    assign lhs          = CMP_W'({s2_sum_reg, 8'd0});
    assign n_sq         = (2*CNT_W)'(s2_n_reg) * (2*CNT_W)'(s2_n_reg);
    assign verdict      = lhs < CMP_W'(rhs);
    assign stat         = lhs - CMP_W'(n_sq);
    assign file_verdict = all_random_reg && verdict;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_write_en)
        begin
            thr_reg <= cfg_write_data;
        end
    end

    // Byte stage and forwarding control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= byte_in.valid;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    // Byte stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_byte_reg  <= byte_in.payload.data_byte;
            s1_eof_reg   <= byte_in.payload.end_of_file;
            fwd_addr_reg <= s1_byte_reg;
            fwd_cnt_reg  <= cnt_new;
        end
    end

    // Chunk state: bins, sum and length, all cleared when a chunk closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            sum_reg       <= '0;
            n_reg         <= '0;
        end
        else if (s1_fire)
        begin
            if (chunk_close)
            begin
                bin_valid_reg <= '0;
                sum_reg       <= '0;
                n_reg         <= '0;
            end
            else
            begin
                bin_valid_reg[s1_byte_reg] <= 1'b1;
                sum_reg                    <= sum_new;
                n_reg                      <= n_new;
            end
        end
    end

    // Closing stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg && chunk_close;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && chunk_close)
        begin
            s2_sum_reg <= sum_new;
            s2_n_reg   <= n_new;
            s2_eof_reg <= s1_eof_reg;
        end
    end

    // File verdict, restarted after the last chunk of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_random_reg <= 1'b1;
        end
        else if (advance && s2_valid_reg)
        begin
            all_random_reg <= s2_eof_reg ? 1'b1 : file_verdict;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s2_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            out_payload_reg.chunk_random <= verdict;
            out_payload_reg.file_random  <= file_verdict;
            out_payload_reg.file_done    <= s2_eof_reg;
            out_payload_reg.chunk_length <= LEN_W'(s2_n_reg);
            out_payload_reg.chunk_stat   <= STAT_W'(stat);
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = out_payload_reg;

endmodule

// ===== src/bcc_checker.sv =====
`include "assert_macros.svh"

// Port-level checks for the chi-square tester.
module bcc_checker
    import bcc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         in_eof,
    input logic         out_valid,
    input logic         out_ready,
    input result_beat_t out_payload
);

    logic in_last;
    logic out_stall;
    logic out_done;
    logic file_ok;
    logic chunk_ok;

    // Short names for the port conditions that the checks look at
    assign in_last   = in_valid && in_ready && in_eof;
    assign out_stall = out_valid && !out_ready;
    assign out_done  = out_valid && out_payload.file_done;
    assign file_ok   = out_valid && out_payload.file_random;
    assign chunk_ok  = out_payload.chunk_random;

    // No result is shown while reset is applied
    `BCC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result valid during reset")

    // A stalled result keeps its contents
    `BCC_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "stalled beat changed")

    // The file verdict can only be set when this chunk passed as well
    `BCC_ASSERT(a_file_implies_chunk, file_ok |-> chunk_ok, "file pass on failing chunk")

    // The last byte of a file, with the output free, yields a closing result
    `BCC_ASSERT(a_eof_result, in_last ##1 out_ready[*2] |=> out_done, "no result for last chunk")

endmodule

bind byte_chunk_chi_square_tester bcc_checker u_bcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (byte_in.valid),
    .in_ready    (byte_in.ready),
    .in_eof      (byte_in.payload.end_of_file),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_payload (result_out.payload)
);
